// ===== rtl/core/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every clock edge outside reset
`define CHK_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// implication checked on every clock edge, reset included
`define CHK_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/rti_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// rti_pkg
// types, widths and register codes of the ray / triangle intersection block
// ---------------------------------------------------------------------------
package rti_pkg;

    // coordinate and datapath widths
    localparam int COORD_BITS = 20;
    localparam int FRAC_BITS  = 12;
    localparam int EDGE_W     = COORD_BITS + 1;
    localparam int PV_W       = 2 * COORD_BITS + 2 - FRAC_BITS;
    localparam int QV_W       = 2 * EDGE_W + 1 - FRAC_BITS;
    localparam int DET_W      = EDGE_W + PV_W + 2;
    localparam int TN_W       = EDGE_W + QV_W + 2;
    localparam int VERT_W     = 3 * COORD_BITS;
    localparam int DIST_W     = 32;
    localparam int QUO_W      = DIST_W - 1;
    localparam int FRAC_OUT   = 16;
    localparam int SAT_SHIFT  = QUO_W - FRAC_OUT;
    localparam int DET_EPS    = 168;

    // pipeline depth: front end, divider steps, output register
    localparam int FRONT_STAGES = 7;
    localparam int NUM_STAGES   = FRONT_STAGES + QUO_W + 1;

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_VERTEX_FIRST  = 3'd0,
        REG_VERTEX_SECOND = 3'd1,
        REG_VERTEX_THIRD  = 3'd2,
        REG_CULL          = 3'd3
    } cfg_index_t;

    // input beat
    typedef struct packed {
        logic signed [COORD_BITS-1:0] origin_x;
        logic signed [COORD_BITS-1:0] origin_y;
        logic signed [COORD_BITS-1:0] origin_z;
        logic signed [COORD_BITS-1:0] direction_x;
        logic signed [COORD_BITS-1:0] direction_y;
        logic signed [COORD_BITS-1:0] direction_z;
    } ray_t;

    // output beat
    typedef struct packed {
        logic                     hit;
        logic signed [DIST_W-1:0] distance;
    } isect_t;

    // control carried along the divider
    typedef struct packed {
        logic hit;
        logic sat;
        logic neg;
    } div_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/core/ray_triangle_intersect.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// ray_triangle_intersect
// Moller-Trumbore ray / triangle test against a triangle held in registers
// ---------------------------------------------------------------------------
// Takes one ray beat per clock while in_ready is high and returns one result
// beat per ray, in order. The pipeline is formed by the 7-stage multiply /
// reduce front end, the 31 one-bit steps of the restoring divider that forms
// t in Q16.16, and the output register. Each stage holds its beat while its
// successor cannot take it, so bubbles close up and a new ray is taken while
// a finished result waits. Triangle vertices and the culling flag must only be
// written while no ray is in flight.
module ray_triangle_intersect
    import rti_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_write,
    input  wire logic [2:0]        cfg_index,
    input  wire logic [VERT_W-1:0] cfg_data,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire ray_t              in_data,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output isect_t                 out_data
);

    // configuration registers
    logic [VERT_W-1:0] vert_a_reg, vert_b_reg, vert_c_reg;
    logic              cull_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vert_a_reg <= '0;
            vert_b_reg <= '0;
            vert_c_reg <= '0;
            cull_reg   <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_VERTEX_FIRST:  vert_a_reg <= cfg_data;
                REG_VERTEX_SECOND: vert_b_reg <= cfg_data;
                REG_VERTEX_THIRD:  vert_c_reg <= cfg_data;
                REG_CULL:          cull_reg   <= cfg_data[0];
                default:           ;
            endcase
        end
    end

    // vertex unpack and triangle edges, static while rays are in flight
    logic signed [COORD_BITS-1:0] a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z;
    logic signed [EDGE_W-1:0]     ab_x, ab_y, ab_z, ac_x, ac_y, ac_z;

    assign a_x  = vert_a_reg[COORD_BITS-1:0];
    assign a_y  = vert_a_reg[2*COORD_BITS-1:COORD_BITS];
    assign a_z  = vert_a_reg[3*COORD_BITS-1:2*COORD_BITS];
    assign b_x  = vert_b_reg[COORD_BITS-1:0];
    assign b_y  = vert_b_reg[2*COORD_BITS-1:COORD_BITS];
    assign b_z  = vert_b_reg[3*COORD_BITS-1:2*COORD_BITS];
    assign c_x  = vert_c_reg[COORD_BITS-1:0];
    assign c_y  = vert_c_reg[2*COORD_BITS-1:COORD_BITS];
    assign c_z  = vert_c_reg[3*COORD_BITS-1:2*COORD_BITS];
    assign ab_x = EDGE_W'(b_x) - EDGE_W'(a_x);
    assign ab_y = EDGE_W'(b_y) - EDGE_W'(a_y);
    assign ab_z = EDGE_W'(b_z) - EDGE_W'(a_z);
    assign ac_x = EDGE_W'(c_x) - EDGE_W'(a_x);
    assign ac_y = EDGE_W'(c_y) - EDGE_W'(a_y);
    assign ac_z = EDGE_W'(c_z) - EDGE_W'(a_z);

    // pipeline valid bits and per-stage load enables
    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] load;

    always_comb
    begin
        load[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || out_ready;
        for (int i = NUM_STAGES - 2; i >= 0; i--)
        begin
            load[i] = !valid_reg[i] || load[i+1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (load[0])
            begin
                valid_reg[0] <= in_valid;
            end
            for (int i = 1; i < NUM_STAGES; i++)
            begin
                if (load[i])
                begin
                    valid_reg[i] <= valid_reg[i-1];
                end
            end
        end
    end

    assign in_ready = load[0];

    // stage 1: origin relative to vertex a
    logic signed [EDGE_W-1:0]     s1_tv_x_reg, s1_tv_y_reg, s1_tv_z_reg;
    logic signed [COORD_BITS-1:0] s1_d_x_reg, s1_d_y_reg, s1_d_z_reg;

    always_ff @(posedge clk)
    begin
        if (load[0])
        begin
            s1_tv_x_reg <= EDGE_W'(in_data.origin_x) - EDGE_W'(a_x);
            s1_tv_y_reg <= EDGE_W'(in_data.origin_y) - EDGE_W'(a_y);
            s1_tv_z_reg <= EDGE_W'(in_data.origin_z) - EDGE_W'(a_z);
            s1_d_x_reg  <= in_data.direction_x;
            s1_d_y_reg  <= in_data.direction_y;
            s1_d_z_reg  <= in_data.direction_z;
        end
    end

    // stage 2: cross product terms of dir x ac and tv x ab
    localparam int PP_W = COORD_BITS + EDGE_W;
    localparam int QP_W = 2 * EDGE_W;

    logic signed [PP_W-1:0]       s2_p0_reg, s2_p1_reg, s2_p2_reg;
    logic signed [PP_W-1:0]       s2_p3_reg, s2_p4_reg, s2_p5_reg;
    logic signed [QP_W-1:0]       s2_q0_reg, s2_q1_reg, s2_q2_reg;
    logic signed [QP_W-1:0]       s2_q3_reg, s2_q4_reg, s2_q5_reg;
    logic signed [EDGE_W-1:0]     s2_tv_x_reg, s2_tv_y_reg, s2_tv_z_reg;
    logic signed [COORD_BITS-1:0] s2_d_x_reg, s2_d_y_reg, s2_d_z_reg;

    always_ff @(posedge clk)
    begin
        if (load[1])
        begin
            s2_p0_reg   <= PP_W'(s1_d_y_reg) * PP_W'(ac_z);
            s2_p1_reg   <= PP_W'(s1_d_z_reg) * PP_W'(ac_y);
            s2_p2_reg   <= PP_W'(s1_d_z_reg) * PP_W'(ac_x);
            s2_p3_reg   <= PP_W'(s1_d_x_reg) * PP_W'(ac_z);
            s2_p4_reg   <= PP_W'(s1_d_x_reg) * PP_W'(ac_y);
            s2_p5_reg   <= PP_W'(s1_d_y_reg) * PP_W'(ac_x);
            s2_q0_reg   <= QP_W'(s1_tv_y_reg) * QP_W'(ab_z);
            s2_q1_reg   <= QP_W'(s1_tv_z_reg) * QP_W'(ab_y);
            s2_q2_reg   <= QP_W'(s1_tv_z_reg) * QP_W'(ab_x);
            s2_q3_reg   <= QP_W'(s1_tv_x_reg) * QP_W'(ab_z);
            s2_q4_reg   <= QP_W'(s1_tv_x_reg) * QP_W'(ab_y);
            s2_q5_reg   <= QP_W'(s1_tv_y_reg) * QP_W'(ab_x);
            s2_tv_x_reg <= s1_tv_x_reg;
            s2_tv_y_reg <= s1_tv_y_reg;
            s2_tv_z_reg <= s1_tv_z_reg;
            s2_d_x_reg  <= s1_d_x_reg;
            s2_d_y_reg  <= s1_d_y_reg;
            s2_d_z_reg  <= s1_d_z_reg;
        end
    end

    // stage 3: pvec and qvec, reduced to q.12 by flooring shift
    logic signed [PP_W:0] pd_x, pd_y, pd_z;
    logic signed [QP_W:0] qd_x, qd_y, qd_z;

    assign pd_x = (PP_W+1)'(s2_p0_reg) - (PP_W+1)'(s2_p1_reg);
    assign pd_y = (PP_W+1)'(s2_p2_reg) - (PP_W+1)'(s2_p3_reg);
    assign pd_z = (PP_W+1)'(s2_p4_reg) - (PP_W+1)'(s2_p5_reg);
    assign qd_x = (QP_W+1)'(s2_q0_reg) - (QP_W+1)'(s2_q1_reg);
    assign qd_y = (QP_W+1)'(s2_q2_reg) - (QP_W+1)'(s2_q3_reg);
    assign qd_z = (QP_W+1)'(s2_q4_reg) - (QP_W+1)'(s2_q5_reg);

    logic signed [PV_W-1:0]       s3_pv_x_reg, s3_pv_y_reg, s3_pv_z_reg;
    logic signed [QV_W-1:0]       s3_qv_x_reg, s3_qv_y_reg, s3_qv_z_reg;
    logic signed [EDGE_W-1:0]     s3_tv_x_reg, s3_tv_y_reg, s3_tv_z_reg;
    logic signed [COORD_BITS-1:0] s3_d_x_reg, s3_d_y_reg, s3_d_z_reg;

    always_ff @(posedge clk)
    begin
        if (load[2])
        begin
            s3_pv_x_reg <= pd_x[PP_W:FRAC_BITS];
            s3_pv_y_reg <= pd_y[PP_W:FRAC_BITS];
            s3_pv_z_reg <= pd_z[PP_W:FRAC_BITS];
            s3_qv_x_reg <= qd_x[QP_W:FRAC_BITS];
            s3_qv_y_reg <= qd_y[QP_W:FRAC_BITS];
            s3_qv_z_reg <= qd_z[QP_W:FRAC_BITS];
            s3_tv_x_reg <= s2_tv_x_reg;
            s3_tv_y_reg <= s2_tv_y_reg;
            s3_tv_z_reg <= s2_tv_z_reg;
            s3_d_x_reg  <= s2_d_x_reg;
            s3_d_y_reg  <= s2_d_y_reg;
            s3_d_z_reg  <= s2_d_z_reg;
        end
    end

    // stage 4: dot product terms for det, u, v and t
    localparam int DP_W = DET_W - 2;
    localparam int TP_W = TN_W - 2;

    logic signed [DP_W-1:0] s4_det0_reg, s4_det1_reg, s4_det2_reg;
    logic signed [DP_W-1:0] s4_u0_reg, s4_u1_reg, s4_u2_reg;
    logic signed [DP_W-1:0] s4_v0_reg, s4_v1_reg, s4_v2_reg;
    logic signed [TP_W-1:0] s4_t0_reg, s4_t1_reg, s4_t2_reg;

    always_ff @(posedge clk)
    begin
        if (load[3])
        begin
            s4_det0_reg <= DP_W'(ab_x) * DP_W'(s3_pv_x_reg);
            s4_det1_reg <= DP_W'(ab_y) * DP_W'(s3_pv_y_reg);
            s4_det2_reg <= DP_W'(ab_z) * DP_W'(s3_pv_z_reg);
            s4_u0_reg   <= DP_W'(s3_tv_x_reg) * DP_W'(s3_pv_x_reg);
            s4_u1_reg   <= DP_W'(s3_tv_y_reg) * DP_W'(s3_pv_y_reg);
            s4_u2_reg   <= DP_W'(s3_tv_z_reg) * DP_W'(s3_pv_z_reg);
            s4_v0_reg   <= DP_W'(s3_d_x_reg) * DP_W'(s3_qv_x_reg);
            s4_v1_reg   <= DP_W'(s3_d_y_reg) * DP_W'(s3_qv_y_reg);
            s4_v2_reg   <= DP_W'(s3_d_z_reg) * DP_W'(s3_qv_z_reg);
            s4_t0_reg   <= TP_W'(ac_x) * TP_W'(s3_qv_x_reg);
            s4_t1_reg   <= TP_W'(ac_y) * TP_W'(s3_qv_y_reg);
            s4_t2_reg   <= TP_W'(ac_z) * TP_W'(s3_qv_z_reg);
        end
    end

    // stage 5: det and the numerators of u, v and t
    logic signed [DET_W-1:0] s5_det_reg, s5_un_reg, s5_vn_reg;
    logic signed [TN_W-1:0]  s5_tn_reg;

    always_ff @(posedge clk)
    begin
        if (load[4])
        begin
            s5_det_reg <= DET_W'(s4_det0_reg) + DET_W'(s4_det1_reg) + DET_W'(s4_det2_reg);
            s5_un_reg  <= DET_W'(s4_u0_reg) + DET_W'(s4_u1_reg) + DET_W'(s4_u2_reg);
            s5_vn_reg  <= DET_W'(s4_v0_reg) + DET_W'(s4_v1_reg) + DET_W'(s4_v2_reg);
            s5_tn_reg  <= TN_W'(s4_t0_reg) + TN_W'(s4_t1_reg) + TN_W'(s4_t2_reg);
        end
    end

    // stage 6: determinant and barycentric range tests, magnitudes
    localparam logic signed [DET_W-1:0] EPS = DET_W'(DET_EPS);

    logic signed [DET_W:0] uv_sum, det_ext;
    logic                  det_small, range_miss;

    assign uv_sum  = (DET_W+1)'(s5_un_reg) + (DET_W+1)'(s5_vn_reg);
    assign det_ext = (DET_W+1)'(s5_det_reg);

    always_comb
    begin
        if (cull_reg)
        begin
            det_small = s5_det_reg < EPS;
        end
        else
        begin
            det_small = (s5_det_reg < EPS) && (s5_det_reg > -EPS);
        end
        if (s5_det_reg > 0)
        begin
            range_miss = (s5_un_reg < 0) || (s5_un_reg > s5_det_reg) ||
                         (s5_vn_reg < 0) || (uv_sum > det_ext);
        end
        else
        begin
            range_miss = (s5_un_reg > 0) || (s5_un_reg < s5_det_reg) ||
                         (s5_vn_reg > 0) || (uv_sum < det_ext);
        end
    end

    logic              s6_hit_reg, s6_neg_reg;
    logic [TN_W-1:0]   s6_nmag_reg;
    logic [DET_W-1:0]  s6_dmag_reg;

    always_ff @(posedge clk)
    begin
        if (load[5])
        begin
            s6_hit_reg  <= !det_small && !range_miss;
            s6_neg_reg  <= s5_tn_reg[TN_W-1] ^ s5_det_reg[DET_W-1];
            s6_nmag_reg <= s5_tn_reg[TN_W-1] ? TN_W'(-s5_tn_reg) : TN_W'(s5_tn_reg);
            s6_dmag_reg <= s5_det_reg[DET_W-1] ? DET_W'(-s5_det_reg)
                                               : DET_W'(s5_det_reg);
        end
    end

    // stage 7: saturation test and divider setup
    div_ctl_t          s7_ctl_reg;
    logic [DET_W-1:0]  s7_rem_reg, s7_d_reg;
    logic [QUO_W-1:0]  s7_feed_reg;

    always_ff @(posedge clk)
    begin
        if (load[6])
        begin
            s7_ctl_reg.hit <= s6_hit_reg;
            s7_ctl_reg.neg <= s6_neg_reg;
            s7_ctl_reg.sat <= DET_W'(s6_nmag_reg[TN_W-1:SAT_SHIFT]) >= s6_dmag_reg;
            s7_rem_reg     <= DET_W'(s6_nmag_reg[TN_W-1:SAT_SHIFT]);
            s7_feed_reg    <= {s6_nmag_reg[SAT_SHIFT-1:0], FRAC_OUT'(0)};
            s7_d_reg       <= s6_dmag_reg;
        end
    end

    // restoring divider, one quotient bit per stage
    div_ctl_t         dv_ctl_reg  [QUO_W];
    logic [DET_W-1:0] dv_rem_reg  [QUO_W];
    logic [DET_W-1:0] dv_d_reg    [QUO_W];
    logic [QUO_W-1:0] dv_feed_reg [QUO_W];
    logic [QUO_W-1:0] dv_quo_reg  [QUO_W];

    for (genvar k = 0; k < QUO_W; k++)
    begin : g_div
        div_ctl_t         ctl_in;
        logic [DET_W-1:0] rem_in, d_in;
        logic [QUO_W-1:0] feed_in, quo_in;
        logic [DET_W:0]   trial;
        logic             take;

        if (k == 0)
        begin : g_first
            assign ctl_in  = s7_ctl_reg;
            assign rem_in  = s7_rem_reg;
            assign d_in    = s7_d_reg;
            assign feed_in = s7_feed_reg;
            assign quo_in  = '0;
        end
        else
        begin : g_next
            assign ctl_in  = dv_ctl_reg[k-1];
            assign rem_in  = dv_rem_reg[k-1];
            assign d_in    = dv_d_reg[k-1];
            assign feed_in = dv_feed_reg[k-1];
            assign quo_in  = dv_quo_reg[k-1];
        end

        assign trial = {rem_in, feed_in[QUO_W-1]};
        assign take  = trial >= (DET_W+1)'(d_in);

        always_ff @(posedge clk)
        begin
            if (load[FRONT_STAGES+k])
            begin
                dv_ctl_reg[k]  <= ctl_in;
                dv_rem_reg[k]  <= take ? DET_W'(trial - (DET_W+1)'(d_in)) : DET_W'(trial);
                dv_d_reg[k]    <= d_in;
                dv_feed_reg[k] <= {feed_in[QUO_W-2:0], 1'b0};
                dv_quo_reg[k]  <= {quo_in[QUO_W-2:0], take};
            end
        end
    end

    // output register: sign, saturation and miss
    div_ctl_t          fin_ctl;
    logic [QUO_W-1:0]  fin_quo;
    logic [DIST_W-1:0] dist_next;
    isect_t            out_reg;

    assign fin_ctl = dv_ctl_reg[QUO_W-1];
    assign fin_quo = dv_quo_reg[QUO_W-1];

    always_comb
    begin
        if (!fin_ctl.hit)
        begin
            dist_next = '0;
        end
        else if (fin_ctl.sat)
        begin
            dist_next = fin_ctl.neg ? {1'b1, QUO_W'(0)} : {1'b0, {QUO_W{1'b1}}};
        end
        else if (fin_ctl.neg)
        begin
            dist_next = -{1'b0, fin_quo};
        end
        else
        begin
            dist_next = {1'b0, fin_quo};
        end
    end

    always_ff @(posedge clk)
    begin
        if (load[NUM_STAGES-1])
        begin
            out_reg.hit      <= fin_ctl.hit;
            out_reg.distance <= dist_next;
        end
    end

    assign out_valid = valid_reg[NUM_STAGES-1];
    assign out_data  = out_reg;

endmodule

`default_nettype wire

// ===== rtl/core/rti_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// rti_checker
// port-level checks of the intersection block, bound into that module
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module rti_checker
    import rti_pkg::*;
(
    input wire logic   clk,
    input wire logic   rst_n,
    input wire logic   in_valid,
    input wire logic   in_ready,
    input wire logic   out_valid,
    input wire logic   out_ready,
    input wire isect_t out_data
);

    // beats accepted but not yet delivered
    logic [6:0] pend_reg;
    logic       in_beat, out_beat;

    assign in_beat  = in_valid && in_ready;
    assign out_beat = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_reg + 7'(in_beat) - 7'(out_beat);
        end
    end

    // stalled result holds
    `CHK_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_data), "output beat changed while stalled")

    // a miss always reports zero distance
    `CHK_ASSERT(a_miss_zero, clk, rst_n, out_valid && !out_data.hit |-> out_data.distance == 0, "miss with nonzero distance")

    // no result without a ray in flight
    `CHK_ASSERT(a_no_invent, clk, rst_n, out_valid |-> pend_reg != 0, "result beat without accepted ray")

    // never more rays in flight than pipeline stages
    `CHK_ASSERT(a_capacity, clk, rst_n, pend_reg <= 7'(NUM_STAGES), "more rays in flight than stages")

    // nothing leaves during reset
    `CHK_ASSERT_ALWAYS(a_reset_idle, clk, !rst_n |-> !out_valid, "output valid during reset")

endmodule

bind ray_triangle_intersect rti_checker u_rti_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

`default_nettype wire

// ===== test/ray_triangle_intersect_test.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ray_triangle_intersect_test
// self-checking bench for the ray / triangle intersection block
// ---------------------------------------------------------------------------
// Loads several triangles and culling settings, sends directed rays and then
// random rays aimed mostly through the triangle, and compares every result
// beat against an in-bench fixed-point prediction, in order.
module ray_triangle_intersect_test;
    import rti_pkg::*;

    localparam int LATENCY   = 39;
    localparam int CYCLE_CAP = 2000000;
    localparam int EPS_Q24   = 168;

    // expected results kept in acceptance order
    class isect_scoreboard;
        bit [59:0] vtx_a, vtx_b, vtx_c;
        bit        cull;
        isect_t    pending[$];
        int        mismatches;

        function automatic longint sx(logic [19:0] f);
            sx = longint'(signed'(f));
        endfunction

        function automatic longint floor12(longint x);
            floor12 = x >>> 12;
        endfunction

        function automatic bit [31:0] quotient_q16(longint num, longint den);
            bit      neg;
            longint  n, d, q, r;
            neg = (num < 0) != (den < 0);
            n = num < 0 ? -num : num;
            d = den < 0 ? -den : den;
            if (d == 0)
                return 0;
            q = n / d;
            r = n % d;
            if (q >= 32768)
                return neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
            for (int i = 0; i < 16; i++)
            begin
                r = r << 1;
                q = q << 1;
                if (r >= d)
                begin
                    r = r - d;
                    q = q | 1;
                end
            end
            return neg ? 32'(-q) : 32'(q);
        endfunction

        function automatic isect_t predict(ray_t ray);
            longint a[3], b[3], c[3], org[3], dir[3];
            longint ab[3], ac[3], tv[3], pv[3], qv[3];
            longint det, un, vn, tn;
            bit     miss;
            isect_t res;
            for (int k = 0; k < 3; k++)
            begin
                a[k] = sx(vtx_a[20*k +: 20]);
                b[k] = sx(vtx_b[20*k +: 20]);
                c[k] = sx(vtx_c[20*k +: 20]);
            end
            org[0] = sx(ray.origin_x);
            org[1] = sx(ray.origin_y);
            org[2] = sx(ray.origin_z);
            dir[0] = sx(ray.direction_x);
            dir[1] = sx(ray.direction_y);
            dir[2] = sx(ray.direction_z);
            for (int k = 0; k < 3; k++)
            begin
                ab[k] = b[k] - a[k];
                ac[k] = c[k] - a[k];
                tv[k] = org[k] - a[k];
            end
            pv[0] = floor12(dir[1] * ac[2] - dir[2] * ac[1]);
            pv[1] = floor12(dir[2] * ac[0] - dir[0] * ac[2]);
            pv[2] = floor12(dir[0] * ac[1] - dir[1] * ac[0]);
            det = ab[0] * pv[0] + ab[1] * pv[1] + ab[2] * pv[2];
            miss = cull ? (det < EPS_Q24) : (det < EPS_Q24 && det > -EPS_Q24);
            res = '0;
            if (!miss)
            begin
                qv[0] = floor12(tv[1] * ab[2] - tv[2] * ab[1]);
                qv[1] = floor12(tv[2] * ab[0] - tv[0] * ab[2]);
                qv[2] = floor12(tv[0] * ab[1] - tv[1] * ab[0]);
                un = tv[0] * pv[0] + tv[1] * pv[1] + tv[2] * pv[2];
                vn = dir[0] * qv[0] + dir[1] * qv[1] + dir[2] * qv[2];
                if (det > 0)
                    miss = un < 0 || un > det || vn < 0 || un + vn > det;
                else
                    miss = un > 0 || un < det || vn > 0 || un + vn < det;
                if (!miss)
                begin
                    tn = ac[0] * qv[0] + ac[1] * qv[1] + ac[2] * qv[2];
                    res.hit = 1'b1;
                    res.distance = quotient_q16(tn, det);
                end
            end
            return res;
        endfunction

        function void set_reg(cfg_index_t idx, bit [59:0] val);
            case (idx)
                REG_VERTEX_FIRST:  vtx_a = val;
                REG_VERTEX_SECOND: vtx_b = val;
                REG_VERTEX_THIRD:  vtx_c = val;
                REG_CULL:          cull  = val[0];
                default: ;
            endcase
        endfunction

        function void note_ray(ray_t ray);
            pending.push_back(predict(ray));
        endfunction

        function void check_result(isect_t got);
            isect_t want;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: hit=%0d dist=%0d", got.hit, got.distance);
                return;
            end
            want = pending.pop_front();
            if (got.hit !== want.hit || got.distance !== want.distance)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result mismatch: expected hit=%0d dist=%0d, got hit=%0d dist=%0d",
                             want.hit, want.distance, got.hit, got.distance);
            end
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       cfg_write;
    logic [2:0] cfg_index;
    logic [59:0] cfg_data;
    logic       in_valid;
    logic       in_ready;
    ray_t       in_data;
    logic       out_valid;
    logic       out_ready;
    isect_t     out_data;

    isect_scoreboard sb;
    int  send_idle_pct;
    int  recv_idle_pct;
    bit  hold_off;
    int  cycles;
    // current triangle, for aiming random rays
    longint tri_vtx[3][3];

    ray_triangle_intersect dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // watchdog
    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_CAP)
            begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    // receiver: random stalls, plus a long hold-off on request
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
                sb.check_result(out_data);
            if (hold_off)
                out_ready <= 1'b0;
            else
                out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic write_reg(cfg_index_t idx, bit [59:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_write <= 1'b0;
        sb.set_reg(idx, val);
        if (idx != REG_CULL)
            for (int k = 0; k < 3; k++)
                tri_vtx[idx][k] = longint'(signed'(val[20*k +: 20]));
    endtask

    // drop valid after the last ray, then wait for every result
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 5) @(posedge clk);
    endtask

    task automatic load_triangle(bit [59:0] va, bit [59:0] vb, bit [59:0] vc, bit cl);
        write_reg(REG_VERTEX_FIRST, va);
        write_reg(REG_VERTEX_SECOND, vb);
        write_reg(REG_VERTEX_THIRD, vc);
        write_reg(REG_CULL, {59'b0, cl});
    endtask

    // one ray beat, with random gaps before it; valid stays up for the next ray
    task automatic send_ray(ray_t ray);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= ray;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_ray(ray);
    endtask

    function automatic logic [19:0] clip20(longint x);
        if (x > 524287)
            return 20'sd524287;
        if (x < -524288)
            return -20'sd524288;
        return 20'(x);
    endfunction

    function automatic bit [59:0] pack_vtx(longint x, longint y, longint z);
        return {clip20(z), clip20(y), clip20(x)};
    endfunction

    function automatic bit [59:0] rand_vtx(int span);
        return pack_vtx($signed($urandom_range(2 * span)) - span,
                        $signed($urandom_range(2 * span)) - span,
                        $signed($urandom_range(2 * span)) - span);
    endfunction

    // ray aimed at a random point near the triangle, or pure noise
    function automatic ray_t aimed_ray();
        ray_t   r;
        longint u, v, p[3], o[3];
        int     span;
        if ($urandom_range(9) == 0)
            return ray_t'(120'({$urandom, $urandom, $urandom, $urandom}));
        u = $urandom_range(1100);
        v = $urandom_range(1100 - u);
        span = 1 << $urandom_range(8, 18);
        for (int k = 0; k < 3; k++)
        begin
            p[k] = tri_vtx[0][k] + ((tri_vtx[1][k] - tri_vtx[0][k]) * u
                   + (tri_vtx[2][k] - tri_vtx[0][k]) * v) / 1000;
            o[k] = p[k] + $signed($urandom_range(2 * span)) - span;
        end
        r.origin_x    = clip20(o[0]);
        r.origin_y    = clip20(o[1]);
        r.origin_z    = clip20(o[2]);
        r.direction_x = clip20(p[0] - o[0]);
        r.direction_y = clip20(p[1] - o[1]);
        r.direction_z = clip20(p[2] - o[2]);
        if ($urandom_range(3) == 0)
        begin
            r.direction_x = -r.direction_x;
            r.direction_y = -r.direction_y;
            r.direction_z = -r.direction_z;
        end
        return r;
    endfunction

    function automatic ray_t mk_ray(longint ox, longint oy, longint oz,
                                    longint dx, longint dy, longint dz);
        ray_t r;
        r = '{clip20(ox), clip20(oy), clip20(oz), clip20(dx), clip20(dy), clip20(dz)};
        return r;
    endfunction

    // main sequence
    initial
    begin
        sb = new();
        rst_n     = 1'b0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        in_valid  = 1'b0;
        in_data   = '0;
        hold_off  = 1'b0;
        send_idle_pct = 12;
        recv_idle_pct = 82;
        for (int i = 0; i < 3; i++)
            for (int k = 0; k < 3; k++)
                tri_vtx[i][k] = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: unit triangle in z = 0, rays down and up the z axis
        load_triangle(pack_vtx(0, 0, 0), pack_vtx(4096, 0, 0), pack_vtx(0, 4096, 0), 1'b0);
        send_ray(mk_ray(1000, 1000, 4096, 0, 0, -4096));     // hit, t = 1
        send_ray(mk_ray(1000, 1000, -4096, 0, 0, 4096));     // hit from below
        send_ray(mk_ray(1000, 1000, 4096, 0, 0, 4096));      // hit, negative t
        send_ray(mk_ray(5000, 1000, 4096, 0, 0, -4096));     // u out of range
        send_ray(mk_ray(-100, 1000, 4096, 0, 0, -4096));     // u below zero
        send_ray(mk_ray(1000, -100, 4096, 0, 0, -4096));     // v below zero
        send_ray(mk_ray(3000, 3000, 4096, 0, 0, -4096));     // u + v above one
        send_ray(mk_ray(0, 0, 4096, 0, 0, -4096));           // corner exactly
        send_ray(mk_ray(2048, 2048, 4096, 0, 0, -4096));     // on the long edge
        send_ray(mk_ray(1000, 1000, 4096, 4096, 0, 0));      // parallel, det zero
        send_ray(mk_ray(1000, 1000, 524287, 0, 0, -1));      // tiny det, near epsilon
        send_ray(mk_ray(1000, 1000, 524287, 0, 0, -524288)); // extremes
        send_ray(mk_ray(1000, 1000, -524288, 0, 0, 1));      // saturating t
        send_ray(mk_ray(1000, 1000, 524287, 0, 0, -7));      // large t
        send_ray(mk_ray(-524288, -524288, -524288, -524288, -524288, -524288));
        send_ray(mk_ray(524287, 524287, 524287, 524287, 524287, 524287));
        wait_drained();
        // culling: the ray from below now sees a back face
        write_reg(REG_CULL, 60'd1);
        send_ray(mk_ray(1000, 1000, 4096, 0, 0, -4096));
        send_ray(mk_ray(1000, 1000, -4096, 0, 0, 4096));
        send_ray(mk_ray(1000, 1000, 524287, 0, 0, -1));
        wait_drained();
        // degenerate triangle and extreme vertices
        load_triangle(pack_vtx(100, 100, 100), pack_vtx(100, 100, 100),
                      pack_vtx(5, 6, 7), 1'b0);
        send_ray(mk_ray(0, 0, 4096, 0, 0, -4096));
        wait_drained();
        load_triangle(pack_vtx(-524288, -524288, 0), pack_vtx(524287, -524288, 0),
                      pack_vtx(-524288, 524287, 0), 1'b0);
        send_ray(mk_ray(0, 0, 4096, 0, 0, -4096));
        send_ray(mk_ray(0, 0, -524288, 0, 0, 524287));
        wait_drained();

        // random phases: each with a fresh triangle and cull setting
        for (int ph = 0; ph < 14; ph++)
        begin
            int span;
            span = (ph == 13) ? 524287 : (1 << $urandom_range(10, 18));
            load_triangle(rand_vtx(span), rand_vtx(span), rand_vtx(span),
                          (ph % 3 == 1) ? 1'b1 : 1'b0);
            if (ph < 5)
            begin
                send_idle_pct = 12;
                recv_idle_pct = 82;
            end
            else if (ph < 10)
            begin
                send_idle_pct = 82;
                recv_idle_pct = 12;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (ph == 11)
            begin
                // long receiver hold-off while rays keep coming
                fork
                    begin
                        hold_off = 1'b1;
                        repeat (200) @(posedge clk);
                        hold_off = 1'b0;
                    end
                    for (int i = 0; i < 50; i++)
                        send_ray(aimed_ray());
                join
            end
            else
                for (int i = 0; i < 50; i++)
                    send_ray(aimed_ray());
            wait_drained();
        end

        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
